// ----- rtl/core/vfau_pkg.sv -----
// Shared types, codes and constants of the floating arithmetic unit.
// No dependencies; every file of the unit but the interfaces refers to it by scoped names.
package vfau_pkg;

	// Request kind codes
	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;
	localparam logic [2:0] KIND_CMP = 3'd4;

	// Format codes
	localparam logic [1:0] FMT_F = 2'd0;
	localparam logic [1:0] FMT_D = 2'd1;
	localparam logic [1:0] FMT_G = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_RSVD = 3'd1;
	localparam logic [2:0] ST_OVFL = 3'd2;
	localparam logic [2:0] ST_UNFL = 3'd3;
	localparam logic [2:0] ST_DZRO = 3'd4;

	// Compare codes
	localparam logic [1:0] CMP_GT = 2'd0;
	localparam logic [1:0] CMP_EQ = 2'd1;
	localparam logic [1:0] CMP_LT = 2'd2;

	localparam int EXP_W = 14;

	localparam logic [63:0] RND_F = 64'h0000008000000000;
	localparam logic [63:0] RND_D = 64'h0000000000000080;
	localparam logic [63:0] RND_G = 64'h0000000000000400;
	localparam logic [10:0] BIAS_FD = 11'h080;
	localparam logic [10:0] BIAS_G  = 11'h400;
	localparam logic [10:0] MAXEXP_FD = 11'h0FF;
	localparam logic [10:0] MAXEXP_G  = 11'h7FF;
	localparam logic [5:0] STEPS_F = 6'd26;
	localparam logic [5:0] STEPS_D = 6'd58;
	localparam logic [5:0] STEPS_G = 6'd55;

	// Work carried out by the back end
	typedef enum logic [1:0] {
		OP_ADD,
		OP_MUL,
		OP_DIV,
		OP_FIXED
	} vfau_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_MUL,
		S_DIV,
		S_NORM,
		S_ROUND,
		S_PACK
	} vfau_state_t;

	// One classified request waiting for the back end
	typedef struct packed {
		vfau_op_t    op;
		logic [1:0]  fmt;
		logic        sa;
		logic [10:0] ea;
		logic [63:0] fa;
		logic        sb;
		logic [10:0] eb;
		logic [63:0] fb;
		logic [2:0]  status;
		logic [1:0]  code;
	} vfau_entry_t;

endpackage

// ----- rtl/core/vfau_req_if.sv -----
// Request and response channel interfaces of the floating arithmetic unit.
// Depends on nothing; used by the front end, back end and top level.
interface vfau_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [1:0]  format;
	logic [31:0] src1_hi;
	logic [31:0] src1_lo;
	logic [31:0] src2_hi;
	logic [31:0] src2_lo;
	modport source(output valid, kind, format, src1_hi, src1_lo, src2_hi, src2_lo,
		input ready);
	modport sink(input valid, kind, format, src1_hi, src1_lo, src2_hi, src2_lo,
		output ready);
endinterface

interface vfau_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_hi;
	logic [31:0] result_lo;
	logic [1:0]  compare_code;
	logic [2:0]  status;
	modport source(output valid, result_hi, result_lo, compare_code, status,
		input ready);
	modport sink(input valid, result_hi, result_lo, compare_code, status,
		output ready);
endinterface

// ----- rtl/core/vfau_front.sv -----
// Front end: accepts requests, checks operands, settles compare and faults,
// and unpacks operands into queue entries. Depends on vfau_pkg, vfau_req_if.
module vfau_front (
	vfau_req_if.sink           req,
	input  logic               full,
	output logic               push,
	output vfau_pkg::vfau_entry_t entry
);

	logic [31:0] h1, l1, h2, l2;
	logic        isg, ez1, ez2, rsvd, bad;
	logic [31:0] ch1, cl1, ch2, cl2;
	logic [63:0] n1, n2;
	logic [1:0]  cmp;

	// Unpack one operand to a 64-bit fraction with hidden bit at the top (all zero for a zero exponent)
	function automatic logic [63:0] unpack_frac(input logic [1:0] fmt,
		input logic [31:0] h, input logic [31:0] l, input logic ez);
		logic [63:0] f;
		begin
			if (fmt == vfau_pkg::FMT_G) begin
				f = {1'b1, h[3:0], h[31:16], l[15:0], l[31:16], 11'b0};
			end else if (fmt == vfau_pkg::FMT_D) begin
				f = {1'b1, h[6:0], h[31:16], l[15:0], l[31:16], 8'b0};
			end else begin
				f = {1'b1, h[6:0], h[31:16], 40'b0};
			end
			if (ez) begin
				f = '0;
			end
			return f;
		end
	endfunction

	assign req.ready = !full;
	assign push = req.valid && !full;

	// Classify operands
	always_comb begin
		bad = (req.kind > vfau_pkg::KIND_CMP) || (req.format > vfau_pkg::FMT_G);
		isg = (req.format == vfau_pkg::FMT_G);
		h1 = req.src1_hi;
		h2 = req.src2_hi;
		l1 = (req.format == vfau_pkg::FMT_F) ? 32'd0 : req.src1_lo;
		l2 = (req.format == vfau_pkg::FMT_F) ? 32'd0 : req.src2_lo;
		ez1 = isg ? (h1[14:4] == 11'd0) : (h1[14:7] == 8'd0);
		ez2 = isg ? (h2[14:4] == 11'd0) : (h2[14:7] == 8'd0);
		rsvd = (ez1 && h1[15]) || (ez2 && h2[15]);
		ch1 = ez1 ? 32'd0 : h1;
		cl1 = ez1 ? 32'd0 : l1;
		ch2 = ez2 ? 32'd0 : h2;
		cl2 = ez2 ? 32'd0 : l2;
		n1 = {ch1[15:0], ch1[31:16], cl1[15:0], cl1[31:16]};
		n2 = {ch2[15:0], ch2[31:16], cl2[15:0], cl2[31:16]};
		if (ch1[15] != ch2[15]) begin
			cmp = ch1[15] ? vfau_pkg::CMP_LT : vfau_pkg::CMP_GT;
		end else if (n1 == n2) begin
			cmp = vfau_pkg::CMP_EQ;
		end else begin
			cmp = ((n1 < n2) ^ ch1[15]) ? vfau_pkg::CMP_LT : vfau_pkg::CMP_GT;
		end
	end

	// Build the queue entry
	always_comb begin
		entry.fmt = req.format;
		entry.sa = h1[15] ^ (req.kind == vfau_pkg::KIND_SUB);
		entry.ea = isg ? h1[14:4] : {3'b0, h1[14:7]};
		entry.fa = unpack_frac(req.format, h1, l1, ez1);
		entry.sb = h2[15];
		entry.eb = isg ? h2[14:4] : {3'b0, h2[14:7]};
		entry.fb = unpack_frac(req.format, h2, l2, ez2);
		entry.status = vfau_pkg::ST_OK;
		entry.code = 2'd0;
		entry.op = vfau_pkg::OP_FIXED;
		if (bad || rsvd) begin
			entry.status = vfau_pkg::ST_RSVD;
		end else begin
			case (req.kind)
				vfau_pkg::KIND_ADD, vfau_pkg::KIND_SUB: entry.op = vfau_pkg::OP_ADD;
				vfau_pkg::KIND_MUL: entry.op = vfau_pkg::OP_MUL;
				vfau_pkg::KIND_DIV: begin
					if (ez1) begin
						entry.status = vfau_pkg::ST_DZRO;
					end else begin
						entry.op = vfau_pkg::OP_DIV;
					end
				end
				default: entry.code = cmp;
			endcase
		end
	end

endmodule

// ----- rtl/core/vfau_queue.sv -----
// Two-entry queue between the front end and the back end.
// Depends on vfau_pkg for the entry type.
module vfau_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  vfau_pkg::vfau_entry_t wr_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  nonempty,
	output vfau_pkg::vfau_entry_t rd_entry
);

	vfau_pkg::vfau_entry_t mem_q [2];
	logic [1:0] count_q;
	logic       wr_ptr_q, rd_ptr_q;

	assign full = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign rd_entry = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue pop while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule

// ----- rtl/core/vfau_back.sv -----
// Back end: add, multiply by cross products, restoring divide, normalize,
// round, pack, and the output register. Depends on vfau_pkg, vfau_rsp_if.
module vfau_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  unfl_fault_en,
	input  logic                  nonempty,
	input  vfau_pkg::vfau_entry_t entry,
	output logic                  pop,
	vfau_rsp_if.source            rsp
);

	vfau_pkg::vfau_state_t state_q, state_d;
	vfau_pkg::vfau_entry_t cur_q;
	logic                        sign_q;
	logic signed [vfau_pkg::EXP_W-1:0] exp_q;
	logic [63:0]  frac_q;
	logic         zero_q;
	logic [2:0]   cnt_q;
	logic [63:0]  prod_q;
	logic [127:0] acc_q;
	logic [63:0]  rem_q, dvs_q, quo_q;
	logic [5:0]   step_q;
	logic         out_vld_q;
	logic [31:0]  out_hi_q, out_lo_q;
	logic [1:0]   out_code_q;
	logic [2:0]   out_st_q;
	logic         out_wr;

	// Per-format constants
	logic         isg;
	logic [10:0]  bias, maxexp;
	logic [63:0]  rnd;
	logic [5:0]   steps;
	assign isg = (cur_q.fmt == vfau_pkg::FMT_G);
	assign bias = isg ? vfau_pkg::BIAS_G : vfau_pkg::BIAS_FD;
	assign maxexp = isg ? vfau_pkg::MAXEXP_G : vfau_pkg::MAXEXP_FD;
	assign rnd = isg ? vfau_pkg::RND_G :
		(cur_q.fmt == vfau_pkg::FMT_D) ? vfau_pkg::RND_D : vfau_pkg::RND_F;
	assign steps = isg ? vfau_pkg::STEPS_G :
		(cur_q.fmt == vfau_pkg::FMT_D) ? vfau_pkg::STEPS_D : vfau_pkg::STEPS_F;

	// Add and subtract, computed combinationally
	logic        swap, xs, ys, add_s;
	logic [10:0] xe, ye, dexp;
	logic [63:0] xf, yf, nb, add_f;
	logic [64:0] sum;
	logic [10:0] add_e;
	logic        add_inc;
	always_comb begin
		swap = cur_q.ea < cur_q.eb;
		xs = swap ? cur_q.sb : cur_q.sa;
		ys = swap ? cur_q.sa : cur_q.sb;
		xe = swap ? cur_q.eb : cur_q.ea;
		ye = swap ? cur_q.ea : cur_q.eb;
		xf = swap ? cur_q.fb : cur_q.fa;
		yf = swap ? cur_q.fa : cur_q.fb;
		dexp = xe - ye;
		nb = '0;
		sum = '0;
		add_inc = 1'b0;
		add_s = xs;
		add_e = xe;
		add_f = xf;
		if (cur_q.ea == 11'd0) begin
			add_s = cur_q.sb;
			add_e = cur_q.eb;
			add_f = cur_q.fb;
		end else if (cur_q.eb == 11'd0) begin
			add_s = cur_q.sa;
			add_e = cur_q.ea;
			add_f = cur_q.fa;
		end else if (xs != ys) begin
			if (dexp != 11'd0) begin
				if (dexp > 11'd63) begin
					nb = '1;
				end else begin
					nb = ((64'd0 - yf) >> dexp[5:0]) | ~({64{1'b1}} >> dexp[5:0]);
				end
				add_f = xf + nb;
			end else if (xf < yf) begin
				add_f = yf - xf;
				add_s = ys;
			end else begin
				add_f = xf - yf;
			end
		end else begin
			sum = {1'b0, xf} + {1'b0, (dexp > 11'd63) ? 64'd0 : (yf >> dexp[5:0])};
			add_inc = sum[64];
			add_f = sum[64] ? {1'b1, sum[63:1]} : sum[63:0];
		end
	end

	// Cross-product select, one 32x32 product per cycle
	logic [31:0]  ma, mb;
	logic [127:0] acc_n;
	always_comb begin
		unique case (cnt_q[1:0])
			2'd0: begin ma = cur_q.fa[31:0];  mb = cur_q.fb[31:0];  end
			2'd1: begin ma = cur_q.fa[31:0];  mb = cur_q.fb[63:32]; end
			2'd2: begin ma = cur_q.fa[63:32]; mb = cur_q.fb[31:0];  end
			default: begin ma = cur_q.fa[63:32]; mb = cur_q.fb[63:32]; end
		endcase
		case (cnt_q)
			3'd1: acc_n = acc_q + {64'd0, prod_q};
			3'd2, 3'd3: acc_n = acc_q + {32'd0, prod_q, 32'd0};
			default: acc_n = acc_q + {prod_q, 64'd0};
		endcase
	end

	// Rounding
	logic [63:0] rfrac;
	assign rfrac = frac_q + rnd;

	// Packed result
	logic [31:0] pk_hi, pk_lo;
	logic [2:0]  pk_st;
	always_comb begin
		pk_hi = '0;
		pk_lo = '0;
		pk_st = vfau_pkg::ST_OK;
		if (cur_q.op == vfau_pkg::OP_FIXED) begin
			pk_st = cur_q.status;
		end else if (zero_q) begin
			pk_st = vfau_pkg::ST_OK;
		end else if (exp_q > $signed({3'b0, maxexp})) begin
			pk_st = vfau_pkg::ST_OVFL;
		end else if (exp_q <= $signed(14'd0)) begin
			pk_st = unfl_fault_en ? vfau_pkg::ST_UNFL : vfau_pkg::ST_OK;
		end else if (isg) begin
			pk_hi = {frac_q[58:43], sign_q, exp_q[10:0], frac_q[62:59]};
			pk_lo = {frac_q[26:11], frac_q[42:27]};
		end else begin
			pk_hi = {frac_q[55:40], sign_q, exp_q[7:0], frac_q[62:56]};
			pk_lo = (cur_q.fmt == vfau_pkg::FMT_D) ? {frac_q[23:8], frac_q[39:24]} : 32'd0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vfau_pkg::S_IDLE: begin
				if (nonempty) begin
					case (entry.op)
						vfau_pkg::OP_ADD: state_d = vfau_pkg::S_ADD;
						vfau_pkg::OP_MUL: state_d = (entry.ea == 11'd0 || entry.eb == 11'd0) ?
							vfau_pkg::S_NORM : vfau_pkg::S_MUL;
						vfau_pkg::OP_DIV: state_d = (entry.eb == 11'd0) ?
							vfau_pkg::S_NORM : vfau_pkg::S_DIV;
						default: state_d = vfau_pkg::S_PACK;
					endcase
				end
			end
			vfau_pkg::S_ADD: state_d = vfau_pkg::S_NORM;
			vfau_pkg::S_MUL: begin
				if (cnt_q == 3'd4) begin
					state_d = vfau_pkg::S_NORM;
				end
			end
			vfau_pkg::S_DIV: begin
				if (step_q >= steps || rem_q == 64'd0) begin
					state_d = vfau_pkg::S_NORM;
				end
			end
			vfau_pkg::S_NORM: begin
				if (frac_q == 64'd0 || frac_q[63]) begin
					state_d = vfau_pkg::S_ROUND;
				end
			end
			vfau_pkg::S_ROUND: state_d = vfau_pkg::S_PACK;
			vfau_pkg::S_PACK: begin
				if (out_wr) begin
					state_d = vfau_pkg::S_IDLE;
				end
			end
			default: state_d = vfau_pkg::S_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		pop = (state_q == vfau_pkg::S_IDLE) && nonempty;
		out_wr = (state_q == vfau_pkg::S_PACK) && (!out_vld_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfau_pkg::S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_wr) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			vfau_pkg::S_IDLE: begin
				cur_q <= entry;
				cnt_q <= '0;
				step_q <= '0;
				quo_q <= '0;
				acc_q <= '0;
				rem_q <= {1'b0, entry.fb[63:1]};
				dvs_q <= {1'b0, entry.fa[63:1]};
				frac_q <= '0;
				if (entry.op == vfau_pkg::OP_DIV) begin
					sign_q <= entry.sb ^ entry.sa;
					exp_q <= $signed({3'b0, entry.eb}) - $signed({3'b0, entry.ea})
						+ $signed({3'b0, (entry.fmt == vfau_pkg::FMT_G) ?
							vfau_pkg::BIAS_G : vfau_pkg::BIAS_FD}) + 14'sd1;
				end else begin
					sign_q <= entry.sa ^ entry.sb;
					exp_q <= $signed({3'b0, entry.ea}) + $signed({3'b0, entry.eb})
						- $signed({3'b0, (entry.fmt == vfau_pkg::FMT_G) ?
							vfau_pkg::BIAS_G : vfau_pkg::BIAS_FD});
				end
			end
			vfau_pkg::S_ADD: begin
				sign_q <= add_s;
				exp_q <= $signed({3'b0, add_e}) + $signed({13'd0, add_inc});
				frac_q <= add_f;
			end
			vfau_pkg::S_MUL: begin
				prod_q <= ma * mb;
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q != 3'd0) begin
					acc_q <= acc_n;
				end
				if (cnt_q == 3'd4) begin
					frac_q <= acc_n[127:64];
				end
			end
			vfau_pkg::S_DIV: begin
				if (step_q >= steps || rem_q == 64'd0) begin
					frac_q <= quo_q;
				end else begin
					step_q <= step_q + 6'd1;
					if (rem_q >= dvs_q) begin
						rem_q <= (rem_q - dvs_q) << 1;
						quo_q[6'd63 - step_q] <= 1'b1;
					end else begin
						rem_q <= rem_q << 1;
					end
				end
			end
			vfau_pkg::S_NORM: begin
				if (frac_q == 64'd0) begin
					sign_q <= 1'b0;
					exp_q <= '0;
				end else if (frac_q[63:56] == 8'd0) begin
					frac_q <= frac_q << 8;
					exp_q <= exp_q - 14'sd8;
				end else if (!frac_q[63]) begin
					frac_q <= frac_q << 1;
					exp_q <= exp_q - 14'sd1;
				end
			end
			vfau_pkg::S_ROUND: begin
				zero_q <= (frac_q == 64'd0);
				if (!rfrac[63]) begin
					frac_q <= rfrac >> 1;
					exp_q <= exp_q + 14'sd1;
				end else begin
					frac_q <= rfrac;
				end
			end
			default: begin
				if (out_wr) begin
					out_hi_q <= pk_hi;
					out_lo_q <= pk_lo;
					out_st_q <= pk_st;
					out_code_q <= (cur_q.op == vfau_pkg::OP_FIXED) ? cur_q.code : 2'd0;
				end
			end
		endcase
	end

	assign rsp.valid = out_vld_q;
	assign rsp.result_hi = out_hi_q;
	assign rsp.result_lo = out_lo_q;
	assign rsp.compare_code = out_code_q;
	assign rsp.status = out_st_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != vfau_pkg::S_IDLE) else $error("pop without leaving idle");
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr && pk_st != vfau_pkg::ST_OK |-> pk_hi == 32'd0 && pk_lo == 32'd0)
		else $error("faulted result not zero");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !rsp.ready |=> $stable(out_hi_q) && $stable(out_st_q))
		else $error("pending response overwritten");
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vfau_pkg::S_DIV |-> step_q <= vfau_pkg::STEPS_D)
		else $error("divide step count out of range");

endmodule

// ----- rtl/core/vax_float_arith_unit.sv -----
// From request acceptance to response valid: compare and faults go straight to pack; multiply
// or divide with a zero operand goes through normalize, round and pack; add and subtract, multiply
// and divide run their own step first (normalize shifts eight or one bit per cycle), divide
// with one restoring step per cycle, up to 26/58/55 steps.
// Throughput: the back-end sequencer finishes one request before taking the next; a two-entry
// queue and the output register absorb stalls.
// Reset clears queue, sequencer, output valid and the underflow fault enable.
// Top level: holds the configuration register and ties front, queue and back.
// Depends on vfau_pkg, vfau_req_if, vfau_front, vfau_queue, vfau_back.
module vax_float_arith_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	vfau_req_if.sink   req,
	vfau_rsp_if.source rsp
);

	logic                  unfl_en_q;
	logic                  push, full, pop, nonempty;
	vfau_pkg::vfau_entry_t wr_entry, rd_entry;

	// Hold the underflow fault enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unfl_en_q <= 1'b0;
		end else if (cfg_we) begin
			unfl_en_q <= cfg_wdata;
		end
	end

	vfau_front u_front (
		.req   (req),
		.full  (full),
		.push  (push),
		.entry (wr_entry)
	);

	vfau_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.rd_entry (rd_entry)
	);

	vfau_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.unfl_fault_en (unfl_en_q),
		.nonempty      (nonempty),
		.entry         (rd_entry),
		.pop           (pop),
		.rsp           (rsp)
	);

endmodule
